>>> rtl/ppsp_pkg.sv
// Shared constants, types and register codes for the power-state policy block.
package ppsp_pkg;

	localparam int HistDepth = 4;
	localparam int NumTerms  = HistDepth - 2;
	localparam int CntW      = $clog2(NumTerms + 1);
	localparam int TimeW     = 32;
	localparam int CoefW     = 32;
	localparam int ProdW     = TimeW + 1 + CoefW;
	localparam int AccW      = ProdW + CntW;
	localparam int FracW     = 16;
	localparam int PredW     = 48;
	localparam int QW        = AccW - FracW;
	localparam int NumRegs   = 8;
	localparam int RegIdxW   = $clog2(NumRegs);
	localparam int AddrW     = RegIdxW + 2;
	localparam int DataW     = 32;

	localparam logic [1:0] PS_RUN   = 2'd0;
	localparam logic [1:0] PS_IDLE  = 2'd1;
	localparam logic [1:0] PS_SLEEP = 2'd2;
	localparam logic [1:0] PS_BAD   = 2'd3;

	localparam logic [1:0] CMD_DECIDE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_WORK   = 2'd2;

	localparam logic [1:0] POL_TIMEOUT = 2'd0;
	localparam logic [1:0] POL_HISTORY = 2'd1;

	localparam logic [RegIdxW-1:0] REG_POLICY    = 3'd0;
	localparam logic [RegIdxW-1:0] REG_TIMEOUT   = 3'd1;
	localparam logic [RegIdxW-1:0] REG_LOW_STATE = 3'd2;
	localparam logic [RegIdxW-1:0] REG_IDLE_THR  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_SLEEP_THR = 3'd4;
	localparam logic [RegIdxW-1:0] REG_COEF_INT  = 3'd5;
	localparam logic [RegIdxW-1:0] REG_COEF_NEW  = 3'd6;
	localparam logic [RegIdxW-1:0] REG_COEF_SEC  = 3'd7;

	typedef struct packed {
		logic [1:0]       policy_mode;
		logic [TimeW-1:0] timeout_units;
		logic [1:0]       low_state;
		logic [TimeW-1:0] idle_threshold;
		logic [TimeW-1:0] sleep_threshold;
		logic [CoefW-1:0] coef_intercept;
		logic [CoefW-1:0] coef_newest;
		logic [CoefW-1:0] coef_second;
	} cfg_t;

	typedef struct packed {
		logic                             start;
		logic [CoefW-1:0]                 intercept;
		logic [NumTerms-1:0][CoefW-1:0]   coef;
		logic [NumTerms-1:0][TimeW-1:0]   hist;
	} mac_req_t;

	typedef struct packed {
		logic            done;
		logic [AccW-1:0] acc;
	} mac_rsp_t;

endpackage

>>> rtl/ppsp_if.sv
// Valid/ready channel interfaces for command items and result items.
interface ppsp_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [ppsp_pkg::TimeW-1:0]    t_now;

	modport source (output valid, output cmd, output t_now, input ready);
	modport sink (input valid, input cmd, input t_now, output ready);
endinterface

interface ppsp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    power_state;
	logic [ppsp_pkg::PredW-1:0]    prediction;
	logic                          policy_error;

	modport source (output valid, output power_state, output prediction,
		output policy_error, input ready);
	modport sink (input valid, input power_state, input prediction,
		input policy_error, output ready);
endinterface

>>> rtl/ppsp_cfg.sv
// APB-style configuration register file.
module ppsp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppsp_pkg::AddrW-1:0]    paddr,
	input  logic [ppsp_pkg::DataW-1:0]    pwdata,
	output logic [ppsp_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	output ppsp_pkg::cfg_t                cfg
);

	ppsp_pkg::cfg_t                  cfg_q;
	logic [ppsp_pkg::RegIdxW-1:0]    idx;
	logic                            wr_en;

	assign idx    = paddr[ppsp_pkg::AddrW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy_mode     <= '0;
			cfg_q.timeout_units   <= '0;
			cfg_q.low_state       <= ppsp_pkg::PS_IDLE;
			cfg_q.idle_threshold  <= '0;
			cfg_q.sleep_threshold <= '0;
			cfg_q.coef_intercept  <= '0;
			cfg_q.coef_newest     <= '0;
			cfg_q.coef_second     <= '0;
		end else if (wr_en) begin
			unique case (idx)
				ppsp_pkg::REG_POLICY:    cfg_q.policy_mode     <= pwdata[1:0];
				ppsp_pkg::REG_TIMEOUT:   cfg_q.timeout_units   <= pwdata;
				ppsp_pkg::REG_LOW_STATE: cfg_q.low_state       <= pwdata[1:0];
				ppsp_pkg::REG_IDLE_THR:  cfg_q.idle_threshold  <= pwdata;
				ppsp_pkg::REG_SLEEP_THR: cfg_q.sleep_threshold <= pwdata;
				ppsp_pkg::REG_COEF_INT:  cfg_q.coef_intercept  <= pwdata;
				ppsp_pkg::REG_COEF_NEW:  cfg_q.coef_newest     <= pwdata;
				ppsp_pkg::REG_COEF_SEC:  cfg_q.coef_second     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			ppsp_pkg::REG_POLICY:    prdata = {30'd0, cfg_q.policy_mode};
			ppsp_pkg::REG_TIMEOUT:   prdata = cfg_q.timeout_units;
			ppsp_pkg::REG_LOW_STATE: prdata = {30'd0, cfg_q.low_state};
			ppsp_pkg::REG_IDLE_THR:  prdata = cfg_q.idle_threshold;
			ppsp_pkg::REG_SLEEP_THR: prdata = cfg_q.sleep_threshold;
			ppsp_pkg::REG_COEF_INT:  prdata = cfg_q.coef_intercept;
			ppsp_pkg::REG_COEF_NEW:  prdata = cfg_q.coef_newest;
			ppsp_pkg::REG_COEF_SEC:  prdata = cfg_q.coef_second;
			default:                 prdata = '0;
		endcase
	end

endmodule

>>> rtl/ppsp_mac.sv
// Shared multiply-accumulate unit that walks the history weights one term per cycle.
module ppsp_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppsp_pkg::mac_req_t   req,
	output ppsp_pkg::mac_rsp_t   rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [ppsp_pkg::CntW-1:0]         k_q;
	logic [ppsp_pkg::AccW-1:0]         acc_q;
	logic [ppsp_pkg::ProdW-1:0]        prod_q;
	logic [ppsp_pkg::TimeW-1:0]        hist_sel;
	logic [ppsp_pkg::CoefW-1:0]        coef_sel;
	logic signed [ppsp_pkg::ProdW-1:0] prod_d;
	logic                              last;

	always_comb begin
		hist_sel = '0;
		coef_sel = '0;
		for (int i = 0; i < ppsp_pkg::NumTerms; i++) begin
			if (k_q == ppsp_pkg::CntW'(i)) begin
				hist_sel = req.hist[i];
				coef_sel = req.coef[i];
			end
		end
	end

	assign prod_d = $signed({1'b0, hist_sel}) * $signed(coef_sel);
	assign last   = (k_q == ppsp_pkg::CntW'(ppsp_pkg::NumTerms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= {{(ppsp_pkg::AccW-ppsp_pkg::CoefW){req.intercept[ppsp_pkg::CoefW-1]}},
				req.intercept};
			prod_q <= '0;
		end else if (busy_q) begin
			acc_q  <= acc_q + {{(ppsp_pkg::AccW-ppsp_pkg::ProdW){prod_q[ppsp_pkg::ProdW-1]}},
				prod_q};
			prod_q <= prod_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;

endmodule

>>> rtl/predictive_power_state_policy.sv
// Predictive power-state policy top level: sequencer, policy state and result register.
//
// Every command item takes one pass through a small sequencer and yields one result item.
// Inactive-start, work-arrival, timeout decisions and unsupported-policy decisions go
// from the idle state straight to the done state; a history-policy decision passes
// through the calculation state, where the single shared multiplier in the MAC unit
// handles one history weight per cycle. The input is ready only while the sequencer is
// idle; a finished result sits in the output register while the next item is taken.
// Configuration is written over the APB-style port, one register per 32-bit word.
module predictive_power_state_policy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppsp_pkg::AddrW-1:0]    paddr,
	input  logic [ppsp_pkg::DataW-1:0]    pwdata,
	output logic [ppsp_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	ppsp_req_if.sink                      req,
	ppsp_rsp_if.source                    rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_DONE = 3'b100
	} seq_t;

	ppsp_pkg::cfg_t                     cfg;
	ppsp_pkg::mac_req_t                 mac_req;
	ppsp_pkg::mac_rsp_t                 mac_rsp;

	seq_t                               state_q;
	logic [1:0]                         cur_state_q;
	logic [ppsp_pkg::TimeW-1:0]         start_q;
	logic [ppsp_pkg::TimeW-1:0]         hist_q [ppsp_pkg::NumTerms];
	logic [ppsp_pkg::PredW-1:0]         pred_q;
	logic                               err_q;
	logic                               out_valid_q;
	logic [1:0]                         out_state_q;
	logic [ppsp_pkg::PredW-1:0]         out_pred_q;
	logic                               out_err_q;

	logic                               accept;
	logic                               out_load;
	logic                               timeout_hit;
	logic [1:0]                         low_eff;
	logic [ppsp_pkg::TimeW-1:0]         len;
	logic [ppsp_pkg::AccW-1:0]          idle_lim;
	logic [ppsp_pkg::AccW-1:0]          sleep_lim;
	logic                               above_idle;
	logic                               above_sleep;
	logic [1:0]                         hyst_next;
	logic [ppsp_pkg::QW-1:0]            q;
	logic                               sat_hi;
	logic                               sat_lo;
	logic [ppsp_pkg::PredW-1:0]         pred_sat;

	ppsp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppsp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		mac_req.start     = accept && (req.cmd == ppsp_pkg::CMD_DECIDE)
			&& (cfg.policy_mode == ppsp_pkg::POL_HISTORY);
		mac_req.intercept = cfg.coef_intercept;
		for (int i = 0; i < ppsp_pkg::NumTerms; i++) begin
			mac_req.coef[i] = (i == 0) ? cfg.coef_newest : cfg.coef_second;
			mac_req.hist[i] = hist_q[i];
		end
	end

	assign timeout_hit = {1'b0, req.t_now} > ({1'b0, start_q} + {1'b0, cfg.timeout_units});
	assign low_eff     = (cfg.low_state == ppsp_pkg::PS_BAD) ? ppsp_pkg::PS_SLEEP
		: cfg.low_state;
	assign len         = (req.t_now >= start_q) ? (req.t_now - start_q) : '0;

	// thresholds in Q16.16 against the exact sum
	assign idle_lim    = {{(ppsp_pkg::AccW-ppsp_pkg::TimeW-ppsp_pkg::FracW){1'b0}},
		cfg.idle_threshold, {ppsp_pkg::FracW{1'b0}}};
	assign sleep_lim   = {{(ppsp_pkg::AccW-ppsp_pkg::TimeW-ppsp_pkg::FracW){1'b0}},
		cfg.sleep_threshold, {ppsp_pkg::FracW{1'b0}}};
	assign above_idle  = $signed(mac_rsp.acc) > $signed(idle_lim);
	assign above_sleep = $signed(mac_rsp.acc) > $signed(sleep_lim);

	always_comb begin
		hyst_next = ppsp_pkg::PS_RUN;
		unique case (cur_state_q)
			ppsp_pkg::PS_RUN: begin
				if (above_sleep)
					hyst_next = ppsp_pkg::PS_SLEEP;
				else if (above_idle)
					hyst_next = ppsp_pkg::PS_IDLE;
			end
			ppsp_pkg::PS_IDLE: begin
				if (above_idle)
					hyst_next = ppsp_pkg::PS_IDLE;
			end
			ppsp_pkg::PS_SLEEP: begin
				if (above_sleep)
					hyst_next = ppsp_pkg::PS_SLEEP;
			end
			default: hyst_next = ppsp_pkg::PS_RUN;
		endcase
	end

	// floor of the Q16.16 sum, saturated to the output width
	assign q      = mac_rsp.acc[ppsp_pkg::AccW-1:ppsp_pkg::FracW];
	assign sat_hi = !q[ppsp_pkg::QW-1] && (|q[ppsp_pkg::QW-2:ppsp_pkg::PredW-1]);
	assign sat_lo = q[ppsp_pkg::QW-1] && !(&q[ppsp_pkg::QW-2:ppsp_pkg::PredW-1]);
	assign pred_sat = sat_hi ? {1'b0, {(ppsp_pkg::PredW-1){1'b1}}}
		: sat_lo ? {1'b1, {(ppsp_pkg::PredW-1){1'b0}}}
		: q[ppsp_pkg::PredW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_state_q <= ppsp_pkg::PS_RUN;
			start_q     <= '0;
			for (int i = 0; i < ppsp_pkg::NumTerms; i++)
				hist_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= mac_req.start ? S_CALC : S_DONE;
						unique case (req.cmd)
							ppsp_pkg::CMD_DECIDE: begin
								unique case (cfg.policy_mode)
									ppsp_pkg::POL_TIMEOUT:
										cur_state_q <= timeout_hit ? low_eff
											: ppsp_pkg::PS_RUN;
									default: ;
								endcase
							end
							ppsp_pkg::CMD_START: start_q <= req.t_now;
							ppsp_pkg::CMD_WORK: begin
								for (int i = ppsp_pkg::NumTerms - 1; i > 0; i--)
									hist_q[i] <= hist_q[i-1];
								hist_q[0]   <= len;
								cur_state_q <= ppsp_pkg::PS_RUN;
							end
							default: ;
						endcase
					end
				end
				S_CALC: begin
					if (mac_rsp.done) begin
						cur_state_q <= hyst_next;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pred_q <= '0;
			err_q  <= (req.cmd == ppsp_pkg::CMD_DECIDE)
				&& (cfg.policy_mode != ppsp_pkg::POL_TIMEOUT)
				&& (cfg.policy_mode != ppsp_pkg::POL_HISTORY);
		end else if (state_q == S_CALC && mac_rsp.done) begin
			pred_q <= pred_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_state_q <= cur_state_q;
			out_pred_q  <= pred_q;
			out_err_q   <= err_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.power_state  = out_state_q;
	assign rsp.prediction   = out_pred_q;
	assign rsp.policy_error = out_err_q;

`ifndef NO_ASSERTIONS
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.done |-> state_q == S_CALC)
		else $error("mac result outside calc phase");

	a_err_no_pred: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.policy_error |-> rsp.prediction == '0)
		else $error("prediction with policy error");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cur_state_q == ppsp_pkg::PS_RUN || cur_state_q == ppsp_pkg::PS_IDLE
		|| cur_state_q == ppsp_pkg::PS_SLEEP)
		else $error("illegal power state");

	a_work_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == ppsp_pkg::CMD_WORK |=> cur_state_q == ppsp_pkg::PS_RUN)
		else $error("work item did not return to run");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the predictive power-state policy block.
`timescale 1ns / 100ps

module testbench;
	import ppsp_pkg::*;

	localparam logic [1:0] CMD_NONE  = 2'd3;
	localparam logic [1:0] POL_BAD_A = 2'd2;
	localparam logic [1:0] POL_BAD_B = 2'd3;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int RANDOM_ITEMS    = 1300;
	localparam int NUM_SEGMENTS    = 6;
	localparam int NUM_DIRECTED    = 48;

	localparam logic signed [79:0] PRED_MAX = 80'sh7FFF_FFFF_FFFF;
	localparam logic signed [79:0] PRED_MIN = -80'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0]       power_state;
		logic [PredW-1:0] prediction;
		logic             policy_error;
	} decision_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [RegIdxW-1:0] reg_idx;
		logic [1:0]         cmd;
		logic [31:0]        value;
		logic               checked;
		decision_t          lit;
	} stim_row_t;

	localparam decision_t NO_LIT    = '0;
	localparam decision_t LIT_RUN   = '{PS_RUN, 48'd0, 1'b0};
	localparam decision_t LIT_IDLE  = '{PS_IDLE, 48'd0, 1'b0};
	localparam decision_t LIT_SLEEP = '{PS_SLEEP, 48'd0, 1'b0};
	localparam decision_t LIT_ERR   = '{PS_RUN, 48'd0, 1'b1};

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, LIT_RUN},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd1, 1'b1, LIT_IDLE},
		'{ROW_ITEM, '0, CMD_NONE, 32'hFFFF_FFFF, 1'b1, LIT_IDLE},
		'{ROW_ITEM, '0, CMD_WORK, 32'hFFFF_FFFF, 1'b1, LIT_RUN},
		'{ROW_ITEM, '0, CMD_START, 32'hFFFF_FFFF, 1'b1, LIT_RUN},
		'{ROW_WRITE, REG_TIMEOUT, '0, 32'hFFFF_FFFF, 1'b0, NO_LIT},
		// start + timeout must not wrap
		'{ROW_ITEM, '0, CMD_DECIDE, 32'hFFFF_FFFF, 1'b1, LIT_RUN},
		// work before the inactive start: zero length
		'{ROW_ITEM, '0, CMD_WORK, 32'd0, 1'b1, LIT_RUN},
		'{ROW_WRITE, REG_TIMEOUT, '0, 32'd0, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_LOW_STATE, '0, {30'd0, PS_BAD}, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_START, 32'd0, 1'b1, LIT_RUN},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd5, 1'b1, LIT_SLEEP},
		'{ROW_WRITE, REG_LOW_STATE, '0, {30'd0, PS_RUN}, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd5, 1'b1, LIT_RUN},
		'{ROW_WRITE, REG_POLICY, '0, {30'd0, POL_BAD_A}, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd7, 1'b1, LIT_ERR},
		'{ROW_WRITE, REG_POLICY, '0, {30'd0, POL_BAD_B}, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd7, 1'b1, LIT_ERR},
		'{ROW_WRITE, REG_POLICY, '0, {30'd0, POL_HISTORY}, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, LIT_RUN},
		'{ROW_WRITE, REG_COEF_INT, '0, 32'h0001_0000, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, '{PS_SLEEP, 48'd1, 1'b0}},
		// fraction alone lifts the sum above a zero threshold
		'{ROW_WRITE, REG_COEF_INT, '0, 32'h0000_0001, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, LIT_SLEEP},
		'{ROW_WRITE, REG_COEF_INT, '0, 32'h8000_0000, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, '{PS_RUN, 48'hFFFF_FFFF_8000, 1'b0}},
		'{ROW_WRITE, REG_COEF_INT, '0, 32'h7FFF_FFFF, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_NEW, '0, 32'h7FFF_FFFF, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_SEC, '0, 32'h7FFF_FFFF, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_START, 32'd0, 1'b1, LIT_RUN},
		'{ROW_ITEM, '0, CMD_WORK, 32'hFFFF_FFFF, 1'b1, LIT_RUN},
		'{ROW_ITEM, '0, CMD_WORK, 32'hFFFF_FFFF, 1'b1, LIT_RUN},
		// prediction saturates high, then low
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, '{PS_SLEEP, 48'h7FFF_FFFF_FFFF, 1'b0}},
		'{ROW_WRITE, REG_COEF_NEW, '0, 32'h8000_0000, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_SEC, '0, 32'h8000_0000, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b1, '{PS_RUN, 48'h8000_0000_0000, 1'b0}},
		'{ROW_WRITE, REG_IDLE_THR, '0, 32'd10, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_SLEEP_THR, '0, 32'd20, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_INT, '0, 32'd0, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_NEW, '0, 32'h0001_0000, 1'b0, NO_LIT},
		'{ROW_WRITE, REG_COEF_SEC, '0, 32'd0, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_START, 32'd100, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_WORK, 32'd115, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd0, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_WORK, 32'd125, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd9, 1'b0, NO_LIT},
		// sleep left when its threshold goes out of reach
		'{ROW_WRITE, REG_SLEEP_THR, '0, 32'hFFFF_FFFF, 1'b0, NO_LIT},
		'{ROW_ITEM, '0, CMD_DECIDE, 32'd9, 1'b0, NO_LIT}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	ppsp_req_if req_ch ();
	ppsp_rsp_if rsp_ch ();

	predictive_power_state_policy dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always #4 clk = ~clk;

	// predictor state and its copy of the registers
	cfg_t        policy_cfg;
	logic [1:0]  model_state;
	logic [31:0] inactive_t0;
	logic [31:0] idle_len_hist [HistDepth];

	decision_t pending_decisions [$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_off_req = 1'b0;
	int   items_sent = 0;
	int   results_checked = 0;
	int   reg_writes = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	int   seen_run = 0;
	int   seen_idle = 0;
	int   seen_sleep = 0;
	int   seen_err = 0;

	function automatic decision_t apply_power_command(input logic [1:0] c, input logic [31:0] t);
		decision_t         r;
		logic signed [79:0] acc;
		logic signed [79:0] q;
		logic               over_sleep;
		logic               over_idle;
		logic [32:0]        deadline;
		r = '0;
		case (c)
		CMD_DECIDE: begin
			if (policy_cfg.policy_mode == POL_TIMEOUT) begin
				deadline = {1'b0, inactive_t0} + {1'b0, policy_cfg.timeout_units};
				if ({1'b0, t} > deadline)
					model_state = (policy_cfg.low_state == PS_BAD) ? PS_SLEEP
						: policy_cfg.low_state;
				else
					model_state = PS_RUN;
			end else if (policy_cfg.policy_mode == POL_HISTORY) begin
				// exact Q16.16 sum over the two newest lengths
				acc = $signed({{48{policy_cfg.coef_intercept[31]}}, policy_cfg.coef_intercept})
					+ $signed({48'd0, idle_len_hist[HistDepth-1]})
					* $signed({{48{policy_cfg.coef_newest[31]}}, policy_cfg.coef_newest})
					+ $signed({48'd0, idle_len_hist[HistDepth-2]})
					* $signed({{48{policy_cfg.coef_second[31]}}, policy_cfg.coef_second});
				over_sleep = acc > $signed({32'd0, policy_cfg.sleep_threshold, 16'd0});
				over_idle  = acc > $signed({32'd0, policy_cfg.idle_threshold, 16'd0});
				case (model_state)
				PS_RUN:   model_state = over_sleep ? PS_SLEEP : (over_idle ? PS_IDLE : PS_RUN);
				PS_IDLE:  model_state = over_idle ? PS_IDLE : PS_RUN;
				PS_SLEEP: model_state = over_sleep ? PS_SLEEP : PS_RUN;
				default:  model_state = PS_RUN;
				endcase
				q = acc >>> 16;
				if (q > PRED_MAX)
					q = PRED_MAX;
				else if (q < PRED_MIN)
					q = PRED_MIN;
				r.prediction = q[PredW-1:0];
			end else
				r.policy_error = 1'b1;
		end
		CMD_START: inactive_t0 = t;
		CMD_WORK: begin
			for (int i = 0; i < HistDepth - 1; i++)
				idle_len_hist[i] = idle_len_hist[i+1];
			idle_len_hist[HistDepth-1] = (t >= inactive_t0) ? t - inactive_t0 : '0;
			model_state = PS_RUN;
		end
		default: ;
		endcase
		r.power_state = model_state;
		return r;
	endfunction

	function automatic logic [31:0] pick_unsigned(input int unsigned span);
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		2: return $urandom;
		default: return $urandom_range(span);
		endcase
	endfunction

	function automatic logic [31:0] pick_coef(input int span);
		case ($urandom_range(7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return $urandom;
		default: return $urandom_range(2 * span) - span;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] c, input logic [31:0] t, input logic use_lit,
		input decision_t lit);
		decision_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.t_now <= t;
		do @(posedge clk); while (!req_ch.ready);
		want = apply_power_command(c, t);
		pending_decisions.push_back(use_lit ? lit : want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_POLICY:    policy_cfg.policy_mode     = v[1:0];
		REG_TIMEOUT:   policy_cfg.timeout_units   = v;
		REG_LOW_STATE: policy_cfg.low_state       = v[1:0];
		REG_IDLE_THR:  policy_cfg.idle_threshold  = v;
		REG_SLEEP_THR: policy_cfg.sleep_threshold = v;
		REG_COEF_INT:  policy_cfg.coef_intercept  = v;
		REG_COEF_NEW:  policy_cfg.coef_newest     = v;
		REG_COEF_SEC:  policy_cfg.coef_second     = v;
		default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_random_policy();
		logic [1:0] mode;
		int         r;
		r = $urandom_range(99);
		mode = (r < 35) ? POL_TIMEOUT : (r < 90) ? POL_HISTORY : (r < 95) ? POL_BAD_A : POL_BAD_B;
		wait_idle();
		write_reg(REG_POLICY, {30'd0, mode});
		write_reg(REG_TIMEOUT, pick_unsigned(600));
		write_reg(REG_LOW_STATE, $urandom_range(3));
		write_reg(REG_IDLE_THR, pick_unsigned(400));
		write_reg(REG_SLEEP_THR, pick_unsigned(900));
		write_reg(REG_COEF_INT, pick_coef(200 << 16));
		write_reg(REG_COEF_NEW, pick_coef(32'h2_8000));
		write_reg(REG_COEF_SEC, pick_coef(32'h2_8000));
	endtask

	// one inactive phase: start, a few decisions, work arrival, maybe a run-time decision; or one to three random items
	task automatic send_episode();
		logic [31:0] base;
		logic [31:0] d;
		int          n;
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(2'($urandom_range(3)), $urandom, 1'b0, NO_LIT);
		end else begin
			base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
			send_item(CMD_START, base, 1'b0, NO_LIT);
			d = '0;
			n = $urandom_range(4);
			repeat (n) begin
				d = d + $urandom_range(300);
				send_item(CMD_DECIDE, base + d, 1'b0, NO_LIT);
			end
			if ($urandom_range(15) == 0)
				d = -$urandom_range(1, 50);
			else
				d = d + $urandom_range(300);
			send_item(CMD_WORK, base + d, 1'b0, NO_LIT);
			if ($urandom_range(1) == 1)
				send_item(CMD_DECIDE, base + d + $urandom_range(20), 1'b0, NO_LIT);
		end
	endtask

	// result side: random ready, plus one long hold-off on request
	initial begin : receiver
		logic held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		decision_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_decisions.size() == 0) begin
				mismatches++;
				$error("result item with nothing expected: power_state %0d",
					rsp_ch.power_state);
			end else begin
				want = pending_decisions.pop_front();
				results_checked++;
				if (rsp_ch.power_state !== want.power_state) begin
					mismatches++;
					$error("power_state: expected %0d, got %0d", want.power_state,
						rsp_ch.power_state);
				end
				if (rsp_ch.prediction !== want.prediction) begin
					mismatches++;
					$error("prediction: expected %0d, got %0d", $signed(want.prediction),
						$signed(rsp_ch.prediction));
				end
				if (rsp_ch.policy_error !== want.policy_error) begin
					mismatches++;
					$error("policy_error: expected %0d, got %0d", want.policy_error,
						rsp_ch.policy_error);
				end
				case (want.power_state)
				PS_RUN:   seen_run++;
				PS_IDLE:  seen_idle++;
				PS_SLEEP: seen_sleep++;
				default: ;
				endcase
				if (want.policy_error)
					seen_err++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int seg;
		int target;
		int next_program;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_DECIDE;
		req_ch.t_now = '0;
		policy_cfg   = '0;
		policy_cfg.low_state = PS_IDLE;
		model_state  = PS_RUN;
		inactive_t0  = '0;
		for (int i = 0; i < HistDepth; i++)
			idle_len_hist[i] = '0;
		send_idle_pct = 28;
		recv_idle_pct = 81;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
			end else
				send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].value,
					DIRECTED_ROWS[i].checked, DIRECTED_ROWS[i].lit);
		end

		for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
			send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 81 : 0;
			recv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 28 : 0;
			target = items_sent + RANDOM_ITEMS / NUM_SEGMENTS;
			next_program = items_sent;
			while (items_sent < target) begin
				if (items_sent >= next_program) begin
					program_random_policy();
					next_program = items_sent + 50;
					// long result stall while items keep coming
					if (seg == 1)
						hold_off_req = 1'b1;
				end
				send_episode();
			end
		end

		wait_idle();
		$display("Run covered %0d command items, %0d checked results, %0d register writes",
			items_sent, results_checked, reg_writes);
		$display("Results seen: %0d run, %0d idle, %0d sleep, %0d unsupported-policy flags",
			seen_run, seen_idle, seen_sleep, seen_err);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
